// ===== design/per_source_replay_window_filter_unit_assert.svh =====
// assertion macros used by the replay window filter checker
`ifndef PER_SOURCE_REPLAY_WINDOW_FILTER_UNIT_ASSERT_SVH
`define PER_SOURCE_REPLAY_WINDOW_FILTER_UNIT_ASSERT_SVH

// same-cycle implication under reset
`define SRWF_ASSERT_SAME(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication under reset
`define SRWF_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== design/srwf_pkg.sv =====
// package with types and constants of the replay window filter
`default_nettype none
package srwf_pkg;

	localparam int PEERS  = 8;
	localparam int WINDOW = 32;

	localparam int IDX_W = (PEERS > 1) ? $clog2(PEERS) : 1;
	localparam int CNT_W = $clog2(PEERS + 1);

	localparam int SRC_W  = 16;
	localparam int SEQ_W  = 8;
	localparam int TIME_W = 63;
	localparam int STAT_W = 32;

	localparam int S_TDATA_W = 88;
	localparam int M_TDATA_W = 136;

	typedef enum logic [1:0] {
		VERDICT_NEW     = 2'd0,
		VERDICT_DUP     = 2'd1,
		VERDICT_TOO_OLD = 2'd2
	} verdict_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_RESOLVE
	} state_t;

	typedef struct packed {
		logic [SRC_W-1:0]  src;
		logic [SEQ_W-1:0]  newest;
		logic [WINDOW-1:0] seen;
		logic [TIME_W-1:0] last_heard;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} tbl_wr_t;

	typedef struct packed {
		logic     done;
		verdict_t verdict;
		logic     evicted;
	} result_t;

endpackage
`default_nettype wire

// ===== design/per_source_replay_window_filter_unit.sv =====
// top level of the per-source replay window filter
//
// one item in on s_*: tdata carries source_id, sequence_req and time_now;
// one verdict item out on m_* for every item taken, in the same order.
// the block holds a table of up to PEERS sources and walks it with a single
// compare unit: each entry passes a table read state, then a source match
// and least-recently-heard compare state; the walk ends at a match or at
// the end of the table, and the result is then written to the output
// register from the resolve state (an empty table goes straight there).
// s_tready returns once that result is written, so a new item is taken only
// after the last one is through; the registered table read port sets this pace.
// s_tready is high only between items.
// the result lands in an output register, so the next item is accepted
// while it waits; a stalled receiver holds m_tdata steady and the block
// stops before writing the next result until that register is taken.
// the four wrapping statistics counters ride along in every result.
// reset clears the fill count, the counters and the control state; table
// entries are written when a source claims them and need no clearing.
`default_nettype none
module per_source_replay_window_filter_unit
	import srwf_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// source_id[15:0], sequence_req[23:16], time_now[86:24], zero pad
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// verdict[1:0], evicted[2], accepted_total[34:3], duplicate_total[66:35],
	// too_old_total[98:67], eviction_total[130:99], zero pad
	output logic [M_TDATA_W-1:0]      m_tdata
);

	logic [IDX_W-1:0] rd_addr;
	entry_t           rd_data;
	tbl_wr_t          wr;
	result_t          res;
	logic             out_free;

	logic [STAT_W-1:0] acc_q, dup_q, old_q, evc_q;
	logic [STAT_W-1:0] acc_d, dup_d, old_d, evc_d;

	assign out_free = !m_tvalid || m_tready;

	srwf_table u_table (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	srwf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_src   (s_tdata[15:0]),
		.in_seq   (s_tdata[23:16]),
		.in_time  (s_tdata[86:24]),
		.out_free (out_free),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr       (wr),
		.res      (res)
	);

	// counter values after this item
	always_comb begin
		acc_d = acc_q + STAT_W'(res.verdict == VERDICT_NEW);
		dup_d = dup_q + STAT_W'(res.verdict == VERDICT_DUP);
		old_d = old_q + STAT_W'(res.verdict == VERDICT_TOO_OLD);
		evc_d = evc_q + STAT_W'(res.evicted);
	end

	// statistics counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			dup_q <= '0;
			old_q <= '0;
			evc_q <= '0;
		end else if (res.done) begin
			acc_q <= acc_d;
			dup_q <= dup_d;
			old_q <= old_d;
			evc_q <= evc_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (res.done) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (res.done) begin
			m_tdata <= {5'b0, evc_d, old_d, dup_d, acc_d, res.evicted, res.verdict};
		end
	end

endmodule
`default_nettype wire

// ===== design/srwf_table.sv =====
// source table memory: one write port, one registered read port
`default_nettype none
module srwf_table
	import srwf_pkg::*;
(
	input  wire logic             clk,
	input  wire tbl_wr_t          wr,
	input  wire logic [IDX_W-1:0] rd_addr,
	output entry_t                rd_data
);

	entry_t mem [PEERS];

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// ===== design/srwf_ctrl.sv =====
// sequencer that walks the table with one shared compare unit and updates the window
`default_nettype none
module srwf_ctrl
	import srwf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [SRC_W-1:0]  in_src,
	input  wire logic [SEQ_W-1:0]  in_seq,
	input  wire logic [TIME_W-1:0] in_time,
	input  wire logic              out_free,
	output logic [IDX_W-1:0]       rd_addr,
	input  wire entry_t            rd_data,
	output tbl_wr_t                wr,
	output result_t                res
);

	localparam logic [WINDOW-1:0] BIT0     = WINDOW'(1);
	localparam logic [SEQ_W-1:0]  WIN_SEQ  = SEQ_W'(WINDOW);
	localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(PEERS);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  used_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  slot_q;
	logic [IDX_W-1:0]  lru_q;
	logic [TIME_W-1:0] min_q;
	logic              hit_q;
	logic              evict_q;
	logic [SRC_W-1:0]  src_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [TIME_W-1:0] now_q;
	logic [SEQ_W-1:0]  newest_q;
	logic [WINDOW-1:0] seen_q;

	logic              accept;
	logic              match;
	logic              older;
	logic              last_entry;
	logic              full;
	logic [IDX_W-1:0]  lru_sel;
	logic [SEQ_W-1:0]  diff;
	logic [SEQ_W-1:0]  age;
	logic              seen_bit;
	logic [WINDOW-1:0] seen_new;
	verdict_t          verdict;

	assign accept     = in_valid && in_ready;
	assign rd_addr    = idx_q;
	assign match      = (rd_data.src == src_q);
	assign older      = (rd_data.last_heard < min_q);
	assign last_entry = ((CNT_W'(idx_q) + CNT_W'(1)) == used_q);
	assign full       = (used_q == FULL_CNT);
	assign lru_sel    = ((idx_q == '0) || older) ? idx_q : lru_q;

	// window arithmetic on the hit entry
	always_comb begin
		diff     = seq_q - newest_q;
		age      = SEQ_W'(0) - diff;
		seen_bit = |(seen_q & (BIT0 << age));
		seen_new = seen_q;
		verdict  = VERDICT_NEW;
		if (diff != '0 && !diff[SEQ_W-1]) begin
			seen_new = (seen_q << diff) | BIT0;
		end else if (age >= WIN_SEQ) begin
			verdict = VERDICT_TOO_OLD;
		end else if (seen_bit) begin
			verdict = VERDICT_DUP;
		end else begin
			seen_new = seen_q | (BIT0 << age);
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and outputs
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		wr.en       = 1'b0;
		wr.addr     = slot_q;
		wr.data     = '{src: src_q, newest: seq_q, seen: BIT0, last_heard: now_q};
		res.done    = 1'b0;
		res.verdict = VERDICT_NEW;
		res.evicted = evict_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (used_q == '0) ? ST_RESOLVE : ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (match || last_entry) begin
					state_d = ST_RESOLVE;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_RESOLVE: begin
				if (out_free) begin
					wr.en    = 1'b1;
					res.done = 1'b1;
					if (hit_q) begin
						wr.data.newest = (verdict == VERDICT_NEW && seen_new[0]
							&& diff != '0 && !diff[SEQ_W-1]) ? seq_q : newest_q;
						wr.data.seen   = seen_new;
						res.verdict    = verdict;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (state_q == ST_RESOLVE && out_free && !hit_q && !full) begin
			used_q <= used_q + CNT_W'(1);
		end
	end

	// item capture and table walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			hit_q   <= 1'b0;
			evict_q <= 1'b0;
		end else begin
			if (accept) begin
				idx_q   <= '0;
				hit_q   <= 1'b0;
				evict_q <= 1'b0;
			end else if (state_q == ST_CHECK) begin
				if (match) begin
					hit_q <= 1'b1;
				end else if (last_entry) begin
					evict_q <= full;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	// payload registers of the walk
	always_ff @(posedge clk) begin
		if (accept) begin
			src_q  <= in_src;
			seq_q  <= in_seq;
			now_q  <= in_time;
			slot_q <= '0;
		end else if (state_q == ST_CHECK) begin
			min_q <= older || (idx_q == '0) ? rd_data.last_heard : min_q;
			lru_q <= lru_sel;
			if (match) begin
				slot_q   <= idx_q;
				newest_q <= rd_data.newest;
				seen_q   <= rd_data.seen;
			end else if (last_entry) begin
				slot_q <= full ? lru_sel : used_q[IDX_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/srwf_checker.sv =====
// port-level checker for the replay window filter, bound to the top level
`default_nettype none
`include "per_source_replay_window_filter_unit_assert.svh"
module srwf_checker
	import srwf_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata
);

	// busy right after taking an item
	`SRWF_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")

	// stalled result holds
	`SRWF_ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stall lost")

	// verdict code in range
	`SRWF_ASSERT_SAME(a_verdict_code, m_tvalid, m_tdata[1:0] != 2'd3, "bad verdict code")

	// an eviction only comes with a new-source accept
	`SRWF_ASSERT_SAME(a_evict_new, m_tvalid && m_tdata[2], m_tdata[1:0] == 2'd0, "evict not new")

endmodule

bind per_source_replay_window_filter_unit srwf_checker u_srwf_checker (.*);
`default_nettype wire
